// ----- rtl/tfbc_pkg.sv -----
`timescale 1ns / 1ps
package tfbc_pkg;

  localparam int TIME_W  = 32;
  localparam int COLOR_W = 24;
  localparam int CHAN_W  = 8;
  localparam int REM_W   = 32;

  localparam logic [0:0] REG_FADE  = 1'b0;
  localparam logic [0:0] REG_BLINK = 1'b1;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Control bits that travel with one transaction along the divider chain.
  typedef struct packed {
    logic valid;
    logic blink_pass;
  } cell_ctrl_t;

  // Quarter-wave sine entry in unsigned Q1.P, evaluated at elaboration only.
  function automatic longint unsigned quarter_sine(input int unsigned k,
                                                   input int a_bits,
                                                   input int p_bits);
    longint unsigned q;
    longint unsigned kk;
    longint unsigned x;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned fact;
    longint unsigned quo;
    longint unsigned rem;
    q = 64'd1 << (a_bits - 2);
    kk = (longint'(k) > q) ? q : longint'(k);
    x = (HALF_PI_Q30 * kk) >> (a_bits - 2);
    term = x;
    sum = x;
    for (int n = 1; n <= 11; n += 2) begin
      term = (((term * x) >> 30) * x) >> 30;
      fact = longint'((n + 1) * (n + 2));
      // Shift-and-subtract division of the term by the small factorial step.
      quo = 64'd0;
      rem = 64'd0;
      for (int b = 63; b >= 0; b--) begin
        rem = {rem[62:0], term[b]};
        if (rem >= fact) begin
          rem = rem - fact;
          quo[b] = 1'b1;
        end
      end
      term = quo;
      if ((((n + 1) >> 1) & 1) == 1) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    if (sum > (64'd1 << 30)) begin
      sum = 64'd1 << 30;
    end
    sum = (sum + (64'd1 << (29 - p_bits))) >> (30 - p_bits);
    if (sum > (64'd1 << p_bits)) begin
      sum = 64'd1 << p_bits;
    end
    return sum;
  endfunction

endpackage

// ----- rtl/tfbc_cell.sv -----
`timescale 1ns / 1ps
module tfbc_cell
  import tfbc_pkg::*;
#(
  parameter int NB = 42,
  parameter int QB = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [REM_W-1:0]  div_i,
  input  cell_ctrl_t        ctrl_i,
  input  logic [REM_W-1:0]  rem_i,
  input  logic [NB-1:0]     bits_i,
  input  logic [QB-1:0]     quo_i,
  input  logic [COLOR_W-1:0] color_i,
  output cell_ctrl_t        ctrl_o,
  output logic [REM_W-1:0]  rem_o,
  output logic [NB-1:0]     bits_o,
  output logic [QB-1:0]     quo_o,
  output logic [COLOR_W-1:0] color_o
);

  cell_ctrl_t ctrl_q;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [NB-1:0] bits_q;
  logic [QB-1:0] quo_q;
  logic [COLOR_W-1:0] color_q;
  logic [REM_W:0] rem_sh, rem_sub;
  logic ge;

  // One restoring division step: bring down a dividend bit, subtract if it fits.
  always_comb begin
    rem_sh  = {rem_i, bits_i[NB-1]};
    rem_sub = rem_sh - {1'b0, div_i};
    ge      = (rem_sh >= {1'b0, div_i});
    rem_d   = ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q   <= rem_d;
      bits_q  <= {bits_i[NB-2:0], 1'b0};
      quo_q   <= {quo_i[QB-2:0], ge};
      color_q <= color_i;
    end
  end

  assign ctrl_o  = ctrl_q;
  assign rem_o   = rem_q;
  assign bits_o  = bits_q;
  assign quo_o   = quo_q;
  assign color_o = color_q;

`ifndef ASSERT_OFF
  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_q.valid && (div_i != '0) |-> rem_q < div_i)
    else $error("remainder not below divisor");
`endif

endmodule

// ----- rtl/tfbc_shaper.sv -----
`timescale 1ns / 1ps
module tfbc_shaper
  import tfbc_pkg::*;
#(
  parameter int A = 10,
  parameter int P = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [A-1:0]       angle_i,
  input  logic [COLOR_W-1:0] color_i,
  input  logic               blink_pass_i,
  input  logic               fade_en_i,
  input  logic               blink_en_i,
  output logic               valid_o,
  output logic [COLOR_W-1:0] color_o
);

  localparam int Q = 1 << (A - 2);
  localparam logic [P:0] ONE = (P + 1)'(1) << P;

  logic [P:0] tab [0:Q];

  for (genvar g = 0; g <= Q; g++) begin : g_tab
    localparam longint unsigned VAL = quarter_sine(g, A, P);
    assign tab[g] = VAL[P:0];
  end

  logic [1:0] quad;
  logic [A-3:0] k;
  logic [A-2:0] idx;
  logic [P:0] mag, phase_d;

  // The positive half sums to 2.0 at the crest, so it is formed one bit wider.
  always_comb begin
    quad = angle_i[A-1:A-2];
    k    = angle_i[A-3:0];
    idx  = quad[0] ? ((A-1)'(Q) - {1'b0, k}) : {1'b0, k};
    mag  = tab[idx];
    phase_d = quad[1] ? ((ONE - mag) >> 1)
                      : (P + 1)'(({1'b0, ONE} + {1'b0, mag}) >> 1);
  end

  // First stage: phase and mode decision; second stage: channel scaling.
  logic v1_q, v2_q;
  logic [P:0] phase_q;
  logic [COLOR_W-1:0] col1_q, col2_q;
  logic fade_q, black_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  logic [CHAN_W+P:0] pr, pg, pb;

  always_comb begin
    pr = (CHAN_W+P+1)'(col1_q[23:16]) * (CHAN_W+P+1)'(phase_q);
    pg = (CHAN_W+P+1)'(col1_q[15:8])  * (CHAN_W+P+1)'(phase_q);
    pb = (CHAN_W+P+1)'(col1_q[7:0])   * (CHAN_W+P+1)'(phase_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      phase_q <= phase_d;
      col1_q  <= color_i;
      fade_q  <= fade_en_i;
      black_q <= !fade_en_i && blink_en_i && !blink_pass_i;
      if (fade_q) begin
        col2_q <= {pr[P+CHAN_W-1:P], pg[P+CHAN_W-1:P], pb[P+CHAN_W-1:P]};
      end else if (black_q) begin
        col2_q <= '0;
      end else begin
        col2_q <= col1_q;
      end
    end
  end

  assign valid_o = v2_q;
  assign color_o = col2_q;

`ifndef ASSERT_OFF
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> phase_q <= ONE)
    else $error("phase above one");
  a_hold_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && !en_i |=> v1_q && $stable(phase_q) && $stable(col1_q))
    else $error("stalled stage changed");
`endif

endmodule

// ----- rtl/text_fade_blink_color_effect_unit.sv -----
`timescale 1ns / 1ps
// Sine fade / square blink brightness modulation of one RGB888 color per
// transaction. A new transaction is accepted every clock cycle while the output
// side keeps taking results. The time is reduced modulo the active period by a
// row of restoring-division cells, one remainder bit per cell (32 cells),
// followed by SINE_ANGLE_BITS cells that produce the angle index as quotient
// bits. Two final stages look up the quarter-wave sine table, form the phase
// and scale each channel. A nonzero fade period selects the fade; otherwise a
// blink period of two or more gives black while the time within the period is
// at most half of it. Any stall on the output freezes the whole pipeline. The
// two period registers must only be written while no transaction is in flight.
module text_fade_blink_color_effect_unit
  import tfbc_pkg::*;
#(
  parameter int SINE_ANGLE_BITS = 10,
  parameter int PHASE_FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [TIME_W-1:0]  time_ms_i,
  input  logic [COLOR_W-1:0] color_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [COLOR_W-1:0] color_out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int A  = SINE_ANGLE_BITS;
  localparam int NC = TIME_W + A;

  logic [31:0] fade_q, blink_q;

  // Configuration registers, written in the APB access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_q  <= '0;
      blink_q <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_FADE:  fade_q  <= pwdata;
        REG_BLINK: blink_q <= pwdata;
        default: ;
      endcase
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BLINK) ? blink_q : fade_q;

  logic fade_en, blink_en;
  logic [REM_W-1:0] div;
  assign fade_en  = (fade_q != '0);
  assign blink_en = (blink_q > 32'd1);
  assign div      = fade_en ? fade_q : blink_q;

  // Whole pipeline advances together unless a result is waiting to be taken.
  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  cell_ctrl_t         ctrl_w  [0:NC];
  cell_ctrl_t         ctrl_in [0:NC-1];
  logic [REM_W-1:0]   rem_w   [0:NC];
  logic [NC-1:0]      bits_w  [0:NC];
  logic [A-1:0]       quo_w   [0:NC];
  logic [COLOR_W-1:0] color_w [0:NC];

  assign ctrl_w[0]  = '{valid: in_valid_i, blink_pass: 1'b0};
  assign rem_w[0]   = '0;
  assign bits_w[0]  = {time_ms_i, {A{1'b0}}};
  assign quo_w[0]   = '0;
  assign color_w[0] = color_in_i;

  for (genvar i = 0; i < NC; i++) begin : g_chain
    // After the full time word has been reduced, the remainder decides blink.
    if (i == TIME_W) begin : g_tap
      assign ctrl_in[i] = '{valid: ctrl_w[i].valid,
                            blink_pass: (rem_w[i] > (div >> 1))};
    end else begin : g_pass
      assign ctrl_in[i] = ctrl_w[i];
    end
    tfbc_cell #(.NB(NC), .QB(A)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .div_i  (div),
      .ctrl_i (ctrl_in[i]),
      .rem_i  (rem_w[i]),
      .bits_i (bits_w[i]),
      .quo_i  (quo_w[i]),
      .color_i(color_w[i]),
      .ctrl_o (ctrl_w[i+1]),
      .rem_o  (rem_w[i+1]),
      .bits_o (bits_w[i+1]),
      .quo_o  (quo_w[i+1]),
      .color_o(color_w[i+1])
    );
  end

  tfbc_shaper #(.A(A), .P(PHASE_FRAC_BITS)) u_shaper (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (ctrl_w[NC].valid),
    .angle_i     (quo_w[NC]),
    .color_i     (color_w[NC]),
    .blink_pass_i(ctrl_w[NC].blink_pass),
    .fade_en_i   (fade_en),
    .blink_en_i  (blink_en),
    .valid_o     (out_valid_o),
    .color_o     (color_out_o)
  );

`ifndef ASSERT_OFF
  a_accept_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> ctrl_w[1].valid)
    else $error("accepted transaction not captured");
`endif

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// Testbench for text_fade_blink_color_effect_unit.
module tb;
  import tfbc_pkg::*;

  localparam int ANGLE_BITS = 10;
  localparam int FRAC_BITS  = 16;
  // The pipeline is 32 remainder cells, ANGLE_BITS quotient cells and two more.
  localparam int PIPE_DEPTH = 32 + ANGLE_BITS + 2;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [2:0] ADDR_FADE  = 3'd0;
  localparam logic [2:0] ADDR_BLINK = 3'd4;

  // Expected colors, in the order their transactions were accepted. The class
  // also holds its own copy of both period registers.
  class color_scoreboard;
    logic [COLOR_W-1:0] pending[$];
    logic [31:0] fade_ms;
    logic [31:0] blink_ms;
    int errors;
    logic [FRAC_BITS:0] sine_tab[0:(1 << (ANGLE_BITS - 2))];

    function new();
      longint unsigned x, term, sum;
      int q;
      q = 1 << (ANGLE_BITS - 2);
      fade_ms = 0;
      blink_ms = 0;
      errors = 0;
      for (int k = 0; k <= q; k++) begin
        x = (64'd1686629713 * longint'(k)) / longint'(q);
        term = x;
        sum = x;
        for (int n = 1; n <= 11; n += 2) begin
          term = (((term * x) >> 30) * x) >> 30;
          term = term / longint'((n + 1) * (n + 2));
          if ((((n + 1) / 2) % 2) == 1) sum = (sum >= term) ? sum - term : 0;
          else sum = sum + term;
        end
        if (sum > (64'd1 << 30)) sum = 64'd1 << 30;
        sum = (sum + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
        if (sum > (64'd1 << FRAC_BITS)) sum = 64'd1 << FRAC_BITS;
        sine_tab[k] = sum[FRAC_BITS:0];
      end
    endfunction

    function logic [COLOR_W-1:0] modulate(logic [31:0] t, logic [COLOR_W-1:0] c);
      longint unsigned angle, k, quad, mag, phase, ch, res;
      int q;
      q = 1 << (ANGLE_BITS - 2);
      if (fade_ms != 0) begin
        angle = (longint'(t % fade_ms) << ANGLE_BITS) / longint'(fade_ms);
        quad = (angle >> (ANGLE_BITS - 2)) & 3;
        k = angle & (q - 1);
        mag = quad[0] ? sine_tab[q - k] : sine_tab[k];
        phase = (quad < 2) ? ((64'd1 << FRAC_BITS) + mag) >> 1
                           : ((64'd1 << FRAC_BITS) - mag) >> 1;
        res = 0;
        for (int s = 0; s < 3; s++) begin
          ch = (c >> (8 * s)) & 8'hFF;
          res |= (((ch * phase) >> FRAC_BITS) & 8'hFF) << (8 * s);
        end
        return res[COLOR_W-1:0];
      end else if (blink_ms >= 2) begin
        return ((t % blink_ms) > (blink_ms / 2)) ? c : '0;
      end
      return c;
    endfunction

    function void note_input(logic [31:0] t, logic [COLOR_W-1:0] c);
      pending.push_back(modulate(t, c));
    endfunction

    function void check_color(logic [COLOR_W-1:0] got);
      logic [COLOR_W-1:0] want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected color_out, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (want !== got) begin
        $display("%0t: color_out expected %h actual %h", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [TIME_W-1:0] time_ms_i = '0;
  logic [COLOR_W-1:0] color_in_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [COLOR_W-1:0] color_out_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;

  color_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_off = 1'b0;
  int quiet_cycles = 0;

  text_fade_blink_color_effect_unit u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Results are checked at the rising edge; the watchdog counts cycles
  // in which neither channel completes a transaction.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) sb.check_color(color_out_o);
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("text_fade_blink_color_effect_unit: mismatch");
      $finish;
    end
  end

  // The receiver stalls at random, or completely during a hold-off stretch.
  always @(negedge clk_i) begin
    out_ready_i <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  // Register write with a setup and an access phase; waits out the pipeline
  // first so that no transaction is in flight.
  task automatic write_period(logic [2:0] addr, logic [31:0] value);
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (PIPE_DEPTH + 4) @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (addr == ADDR_FADE) sb.fade_ms = value;
    else sb.blink_ms = value;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Offers one transaction and holds it until accepted. Valid is only
  // lowered when an idle gap is actually inserted.
  task automatic send_pixel(logic [31:0] t, logic [COLOR_W-1:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    time_ms_i <= t;
    color_in_i <= c;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_input(t, c);
    @(negedge clk_i);
  endtask

  task automatic end_burst();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Random time, mostly near period boundaries so all quadrants and the
  // blink edge are exercised, sometimes fully random.
  function automatic logic [31:0] pick_time(logic [31:0] period);
    logic [31:0] base;
    if (period == 0 || $urandom_range(3) == 0) return $urandom;
    base = $urandom_range(3) * (period / 4) + $urandom_range(2) - 1;
    return $urandom_range(1) ? base : base + period * $urandom_range(1000);
  endfunction

  task automatic random_phase(int count, logic [31:0] fade, logic [31:0] blink);
    write_period(ADDR_FADE, fade);
    write_period(ADDR_BLINK, blink);
    for (int i = 0; i < count; i++)
      send_pixel(pick_time(fade != 0 ? fade : blink), $urandom);
    end_burst();
  endtask

  initial begin
    logic [31:0] fades[6];
    logic [31:0] blinks[6];
    fades = '{0, 1, 7, 1024, 3000, 32'hFFFF_FFFF};
    blinks = '{0, 1, 2, 3, 1000, 32'hFFFF_FFFF};
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: pass-through after reset, then blink edges and fade quadrants.
    send_pixel(32'h0, 24'hFFFFFF);
    send_pixel(32'hFFFF_FFFF, 24'h000000);
    send_pixel(32'h1234_5678, 24'hA5C35A);
    end_burst();
    write_period(ADDR_BLINK, 32'd1);
    send_pixel(32'd5, 24'hFFFFFF);
    end_burst();
    write_period(ADDR_BLINK, 32'd10);
    // Exactly half the period gives black; one more passes the color.
    send_pixel(32'd5, 24'hFFFFFF);
    send_pixel(32'd6, 24'hFFFFFF);
    send_pixel(32'd0, 24'hFFFFFF);
    send_pixel(32'd9, 24'h123456);
    end_burst();
    // A nonzero fade period takes precedence over blink.
    write_period(ADDR_FADE, 32'd1000);
    for (int i = 0; i < 8; i++) send_pixel(i * 125, 24'hFFFFFF);
    send_pixel(32'hFFFF_FFFF, 24'hFFFFFF);
    send_pixel(32'd999, 24'h808080);
    end_burst();

    // Long receiver hold-off while the sender keeps offering.
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(negedge clk_i);
        hold_off = 1'b0;
      end
      begin
        for (int i = 0; i < 120; i++) send_pixel($urandom, $urandom);
        end_burst();
      end
    join

    send_idle_pct = 12; recv_idle_pct = 60;
    for (int p = 0; p < 6; p++) random_phase(60, fades[p], blinks[5 - p]);
    send_idle_pct = 60; recv_idle_pct = 12;
    for (int p = 0; p < 6; p++) random_phase(60, 0, blinks[p]);
    send_idle_pct = 0; recv_idle_pct = 0;
    for (int p = 0; p < 5; p++)
      random_phase(40, $urandom_range(1) ? $urandom : $urandom_range(1, 5000),
                   $urandom_range(1, 5000));

    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (PIPE_DEPTH + 4) @(negedge clk_i);
    if (sb.errors == 0) $display("text_fade_blink_color_effect_unit: match");
    else $display("text_fade_blink_color_effect_unit: mismatch");
    $finish;
  end
endmodule
